@@ rtl/core/lds_pkg.sv @@
// Shared types and constants for the L4 destination-port frame steering block.
// No dependencies; imported by every module under rtl/core.
package lds_pkg;

    // Table geometry
    localparam int unsigned PORT_TABLE_DEPTH = 65536;
    localparam int unsigned PORT_AW          = $clog2(PORT_TABLE_DEPTH);
    localparam int unsigned SOCKET_SLOTS_DEF = 128;
    localparam int unsigned QIDX_W           = 7;
    localparam int unsigned OP_W             = 2;
    localparam int unsigned POS_W            = 6;

    // Result queue between classifier and output
    localparam int unsigned FIFO_DEPTH = 4;
    localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int unsigned FIFO_CW    = FIFO_AW + 1;

    // Word kinds carried on s_tuser
    localparam logic [OP_W-1:0] OP_FRAME   = 2'd0;
    localparam logic [OP_W-1:0] OP_PORT_WR = 2'd1;
    localparam logic [OP_W-1:0] OP_SOCK_WR = 2'd2;

    // Byte offsets within the frame
    localparam logic [POS_W-1:0] POS_MAX      = 6'd63;
    localparam logic [POS_W-1:0] POS_ETYPE_HI = 6'd12;
    localparam logic [POS_W-1:0] POS_ETYPE_LO = 6'd13;
    localparam logic [POS_W-1:0] V4_HDR_POS   = 6'd14;
    localparam logic [POS_W-1:0] V4_PROTO_POS = 6'd23;
    localparam logic [POS_W-1:0] V4_PORT_HI   = 6'd36;
    localparam logic [POS_W-1:0] V4_PORT_LO   = 6'd37;
    localparam logic [POS_W-1:0] V6_PROTO_POS = 6'd20;
    localparam logic [POS_W-1:0] V6_PORT_HI   = 6'd56;
    localparam logic [POS_W-1:0] V6_PORT_LO   = 6'd57;

    // Header field values
    localparam logic [15:0] TYPE_V4   = 16'h0800;
    localparam logic [15:0] TYPE_V6   = 16'h86dd;
    localparam logic [7:0]  PROTO_TCP = 8'd6;
    localparam logic [7:0]  PROTO_UDP = 8'd17;
    localparam logic [3:0]  IHL_PLAIN = 4'd5;

    typedef enum logic [1:0] {
        KIND_NONE  = 2'd0,
        KIND_V4    = 2'd1,
        KIND_V6    = 2'd2,
        KIND_OTHER = 2'd3
    } kind_t;

    // Table access requests from the classifier
    typedef struct packed {
        logic               port_wr_en;
        logic [PORT_AW-1:0] port_wr_addr;
        logic               port_wr_val;
        logic               port_rd_en;
        logic [PORT_AW-1:0] port_rd_addr;
        logic               sock_wr_en;
        logic               sock_rd_en;
        logic [QIDX_W-1:0]  sock_idx;
        logic               sock_wr_val;
    } tbl_req_t;

    // Frame summary held while the table reads land
    typedef struct packed {
        logic              valid;
        logic              hdr_ok;
        logic              port_seen;
        logic [QIDX_W-1:0] queue;
    } s1_t;

    typedef struct packed {
        logic              verdict;
        logic [QIDX_W-1:0] target_queue;
    } result_t;

endpackage

@@ rtl/core/lds_front.sv @@
// Frame classifier: tracks byte position, ethertype, IP header checks and port.
// Depends on lds_pkg; drives table requests and the per-frame summary register.
module lds_front (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        accept,
    input  logic [lds_pkg::OP_W-1:0]    op,
    input  logic [7:0]                  data_byte,
    input  logic                        last_byte,
    input  logic [lds_pkg::QIDX_W-1:0]  queue_index,
    input  logic [lds_pkg::PORT_AW-1:0] port_number,
    input  logic                        flag_value,
    output lds_pkg::tbl_req_t           req,
    output lds_pkg::s1_t                s1
);
    import lds_pkg::*;

    logic [POS_W-1:0] pos_reg, pos_next;
    kind_t            kind_reg, kind_next;
    logic             hok_reg, hok_next;
    logic [7:0]       phb_reg, phb_next;
    logic             seen_reg, seen_next;
    s1_t              s1_reg, s1_next;

    // Parse one word and build table requests
    always_comb begin
        kind_t      k_upd;
        logic       h_upd;
        logic [7:0] p_upd;
        logic       s_upd;
        logic       proto_ok;

        k_upd    = kind_reg;
        h_upd    = hok_reg;
        p_upd    = phb_reg;
        s_upd    = seen_reg;
        proto_ok = (data_byte == PROTO_TCP) || (data_byte == PROTO_UDP);

        pos_next  = pos_reg;
        kind_next = kind_reg;
        hok_next  = hok_reg;
        phb_next  = phb_reg;
        seen_next = seen_reg;
        s1_next   = '0;
        s1_next.queue = queue_index;

        req              = '0;
        req.port_wr_addr = port_number;
        req.port_wr_val  = flag_value;
        req.port_rd_addr = {phb_reg, data_byte};
        req.sock_idx     = queue_index;
        req.sock_wr_val  = flag_value;

        if (accept) begin
            unique case (op)
                OP_PORT_WR: req.port_wr_en = 1'b1;
                OP_SOCK_WR: req.sock_wr_en = 1'b1;
                OP_FRAME: begin
                    if (pos_reg == POS_ETYPE_HI) begin
                        p_upd = data_byte;
                    end else if (pos_reg == POS_ETYPE_LO) begin
                        if ({phb_reg, data_byte} == TYPE_V4) begin
                            k_upd = KIND_V4;
                        end else if ({phb_reg, data_byte} == TYPE_V6) begin
                            k_upd = KIND_V6;
                        end else begin
                            k_upd = KIND_OTHER;
                        end
                        p_upd = 8'd0;
                    end else if (kind_reg == KIND_V4) begin
                        if (pos_reg == V4_HDR_POS && data_byte[3:0] != IHL_PLAIN) h_upd = 1'b0;
                        if (pos_reg == V4_PROTO_POS && !proto_ok) h_upd = 1'b0;
                        if (pos_reg == V4_PORT_HI) p_upd = data_byte;
                        if (pos_reg == V4_PORT_LO) begin
                            req.port_rd_en = 1'b1;
                            s_upd          = 1'b1;
                        end
                    end else if (kind_reg == KIND_V6) begin
                        if (pos_reg == V6_PROTO_POS && !proto_ok) h_upd = 1'b0;
                        if (pos_reg == V6_PORT_HI) p_upd = data_byte;
                        if (pos_reg == V6_PORT_LO) begin
                            req.port_rd_en = 1'b1;
                            s_upd          = 1'b1;
                        end
                    end

                    if (pos_reg != POS_MAX) pos_next = pos_reg + 1'b1;
                    kind_next = k_upd;
                    hok_next  = h_upd;
                    phb_next  = p_upd;
                    seen_next = s_upd;

                    // End of frame: hand off summary, return to reset state
                    if (last_byte) begin
                        req.sock_rd_en    = 1'b1;
                        s1_next.valid     = 1'b1;
                        s1_next.hdr_ok    = h_upd && (k_upd == KIND_V4 || k_upd == KIND_V6);
                        s1_next.port_seen = s_upd;
                        pos_next  = '0;
                        kind_next = KIND_NONE;
                        hok_next  = 1'b1;
                        phb_next  = 8'd0;
                        seen_next = 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    // Per-frame state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg  <= '0;
            kind_reg <= KIND_NONE;
            hok_reg  <= 1'b1;
            phb_reg  <= 8'd0;
            seen_reg <= 1'b0;
            s1_reg   <= '0;
        end else begin
            pos_reg  <= pos_next;
            kind_reg <= kind_next;
            hok_reg  <= hok_next;
            phb_reg  <= phb_next;
            seen_reg <= seen_next;
            s1_reg   <= s1_next;
        end
    end

    assign s1 = s1_reg;

endmodule

@@ rtl/core/lds_tables.sv @@
// Port-handled and socket-present flag tables with registered reads.
// Depends on lds_pkg; the port table is swept to zero after reset.
module lds_tables #(
    parameter int unsigned SOCKET_SLOTS = lds_pkg::SOCKET_SLOTS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  lds_pkg::tbl_req_t req,
    output logic              port_hit,
    output logic              sock_hit,
    output logic              clr_busy
);
    import lds_pkg::*;

    localparam int unsigned SLOT_AW = (SOCKET_SLOTS > 1) ? $clog2(SOCKET_SLOTS) : 1;

    logic               port_mem [PORT_TABLE_DEPTH];
    logic               sock_mem [SOCKET_SLOTS];
    logic [SOCKET_SLOTS-1:0] sock_vld_reg, sock_vld_next;
    logic               clr_busy_reg, clr_busy_next;
    logic [PORT_AW-1:0] clr_addr_reg, clr_addr_next;
    logic               port_rd_reg;
    logic               sock_rd_reg;
    logic               slot_ok;
    logic [SLOT_AW-1:0] slot;

    assign slot    = req.sock_idx[SLOT_AW-1:0];
    assign slot_ok = {1'b0, req.sock_idx} < (QIDX_W+1)'(SOCKET_SLOTS);

    // Clearing sweep over the port table
    always_comb begin
        clr_busy_next = clr_busy_reg;
        clr_addr_next = clr_addr_reg;
        if (clr_busy_reg) begin
            clr_addr_next = clr_addr_reg + 1'b1;
            if (clr_addr_reg == {PORT_AW{1'b1}}) clr_busy_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end else begin
            clr_busy_reg <= clr_busy_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    // Port table: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (clr_busy_reg) begin
            port_mem[clr_addr_reg] <= 1'b0;
        end else if (req.port_wr_en) begin
            port_mem[req.port_wr_addr] <= req.port_wr_val;
        end
        if (req.port_rd_en) port_rd_reg <= port_mem[req.port_rd_addr];
    end

    // Socket table valid bits
    always_comb begin
        sock_vld_next = sock_vld_reg;
        if (req.sock_wr_en && slot_ok) sock_vld_next[slot] = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) sock_vld_reg <= '0;
        else          sock_vld_reg <= sock_vld_next;
    end

    // Socket table data; unwritten slots read as absent
    always_ff @(posedge aclk) begin
        if (req.sock_wr_en && slot_ok) sock_mem[slot] <= req.sock_wr_val;
        if (req.sock_rd_en) sock_rd_reg <= slot_ok && sock_vld_reg[slot] && sock_mem[slot];
    end

    assign port_hit = port_rd_reg;
    assign sock_hit = sock_rd_reg;
    assign clr_busy = clr_busy_reg;

endmodule

@@ rtl/core/lds_fifo.sv @@
// Verdict queue between the classifier and the result stream.
// Depends on lds_pkg; reports room including a word still in flight.
module lds_fifo (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  lds_pkg::result_t push_data,
    input  logic             inflight,
    output logic             room,
    output logic             out_valid,
    input  logic             out_ready,
    output lds_pkg::result_t out_data
);
    import lds_pkg::*;

    result_t            fifo_mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CW-1:0] count_reg, count_next;
    logic               pop;

    assign pop = out_valid && out_ready;

    // Pointer and fill tracking
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) wr_ptr_next = wr_ptr_reg + 1'b1;
        if (pop)  rd_ptr_next = rd_ptr_reg + 1'b1;
        if (push && !pop)      count_next = count_reg + 1'b1;
        else if (!push && pop) count_next = count_reg - 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) fifo_mem_reg[wr_ptr_reg] <= push_data;
    end

    assign room      = (count_reg + FIFO_CW'(inflight)) < FIFO_CW'(FIFO_DEPTH);
    assign out_valid = count_reg != '0;
    assign out_data  = fifo_mem_reg[rd_ptr_reg];

endmodule

@@ rtl/core/l4_dst_port_frame_steering.sv @@
// Top level of the L4 destination-port frame steering block.
// Depends on lds_pkg, lds_front, lds_tables and lds_fifo.
//
// Takes one word per cycle while s_tready is high: frame bytes (s_tuser 0), port
// flag writes (1) or socket flag writes (2). The classifier follows ethertype,
// IPv4/IPv6 header checks and the TCP/UDP destination port as bytes stream in; on
// the frame's last byte it reads the socket table and registers the frame summary,
// then pushes the verdict into the verdict queue, where a verdict word (m_tuser 1 =
// redirect to queue in m_tdata, 0 = pass) is available. Throughput is one word per
// cycle while s_tready is high, set by the flag tables, which take at most one write
// and one registered read per word. s_tready drops when the four-entry verdict queue
// and the word in flight would fill it. After reset the 65536-entry port table is
// swept to zero, one entry per cycle, and s_tready stays low until the sweep ends.
module l4_dst_port_frame_steering #(
    parameter int unsigned SOCKET_SLOTS = lds_pkg::SOCKET_SLOTS_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [31:0]              s_tdata,  // data_byte[7:0], queue_index[14:8],
                                               // port_number[30:15], flag_value[31]
    input  logic [lds_pkg::OP_W-1:0] s_tuser,  // op[1:0]
    input  logic                     s_tlast,  // last_byte
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [7:0]               m_tdata,  // target_queue[6:0], zero pad[7]
    output logic                     m_tuser   // verdict
);
    import lds_pkg::*;

    tbl_req_t req;
    s1_t      s1;
    result_t  res;
    result_t  head;
    logic     port_hit;
    logic     sock_hit;
    logic     clr_busy;
    logic     room;
    logic     accept;
    logic     redirect;

    assign s_tready = !clr_busy && room;
    assign accept   = s_tvalid && s_tready;

    lds_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .accept      (accept),
        .op          (s_tuser),
        .data_byte   (s_tdata[7:0]),
        .last_byte   (s_tlast),
        .queue_index (s_tdata[14:8]),
        .port_number (s_tdata[30:15]),
        .flag_value  (s_tdata[31]),
        .req         (req),
        .s1          (s1)
    );

    lds_tables #(
        .SOCKET_SLOTS (SOCKET_SLOTS)
    ) u_tables (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req      (req),
        .port_hit (port_hit),
        .sock_hit (sock_hit),
        .clr_busy (clr_busy)
    );

    // Verdict once both table reads have landed
    assign redirect         = s1.hdr_ok && s1.port_seen && port_hit && sock_hit;
    assign res.verdict      = redirect;
    assign res.target_queue = redirect ? s1.queue : '0;

    lds_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (s1.valid),
        .push_data (res),
        .inflight  (s1.valid),
        .room      (room),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (head)
    );

    assign m_tdata = {1'b0, head.target_queue};
    assign m_tuser = head.verdict;

endmodule

@@ rtl/core/lds_checker.sv @@
// Port-level assertions for the L4 destination-port frame steering block.
// Depends on lds_pkg; bound to l4_dst_port_frame_steering below.
module lds_checker (
    input logic                     aclk,
    input logic                     aresetn,
    input logic                     s_tvalid,
    input logic                     s_tready,
    input logic [lds_pkg::OP_W-1:0] s_tuser,
    input logic                     s_tlast,
    input logic                     m_tvalid,
    input logic                     m_tready,
    input logic [7:0]               m_tdata,
    input logic                     m_tuser
);
    import lds_pkg::*;

    logic last_frame_word;
    assign last_frame_word = s_tvalid && s_tready && s_tlast && (s_tuser == OP_FRAME);

    // Stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed while stalled");

    // A pass verdict never names a queue
    a_pass_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata == 8'd0)
        else $error("pass verdict with nonzero queue");

    // A newly valid result word must follow the acceptance of a frame's last byte
    a_out_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(last_frame_word, 2))
        else $error("result without a finished frame");

    // Words are refused as reset is released, while the port table clear starts
    a_clear_hold: assert property (@(posedge aclk)
        $rose(aresetn) |-> !s_tready)
        else $error("input accepted during port table clear");

endmodule

bind l4_dst_port_frame_steering lds_checker u_lds_checker (.*);

@@ sim/tb_l4_dst_port_frame_steering.sv @@
// Self-checking testbench for l4_dst_port_frame_steering.
// Depends on lds_pkg and the RTL under rtl/core. Streams frames and flag-table
// writes, predicts every verdict word and checks it on the result channel.
module tb_l4_dst_port_frame_steering;
    import lds_pkg::*;

    // op 3 has no meaning; the block drops it
    localparam logic [OP_W-1:0] OP_RSVD = 2'd3;
    localparam int unsigned SLOTS          = SOCKET_SLOTS_DEF;
    localparam int unsigned WATCHDOG_LIMIT = 200000;  // covers the port table sweep after reset
    localparam int unsigned ITEM_TARGET    = 1700;
    localparam int unsigned TAIL_CYCLES    = 20;
    localparam int unsigned MAX_PRINTED    = 20;
    localparam int unsigned HOT_PORTS      = 8;
    localparam int unsigned QUIET_WORDS    = 400;

    logic              aclk     = 1'b0;
    logic              aresetn  = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [31:0]       s_tdata  = '0;  // data_byte[7:0], queue_index[14:8],
                                       // port_number[30:15], flag_value[31]
    logic [OP_W-1:0]   s_tuser  = OP_FRAME;  // op[1:0]
    logic              s_tlast  = 1'b0;      // last_byte
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [7:0]        m_tdata;  // target_queue[6:0], zero pad[7]
    logic              m_tuser;  // verdict

    // Shadow of the block's state
    bit                port_flags [PORT_TABLE_DEPTH];
    bit                sock_flags [SLOTS];
    logic [POS_W-1:0]  pos_cnt  = '0;
    kind_t             kind     = KIND_NONE;
    logic              hdr_good = 1'b1;
    logic [7:0]        hi_byte  = '0;
    logic              port_hit = 1'b0;

    result_t           expected_verdicts [$];
    result_t           want;
    logic [7:0]        frame_buf [$];
    logic [15:0]       hot_ports [HOT_PORTS];

    bit                no_idle        = 1'b0;
    int unsigned       err_count      = 0;
    int unsigned       words_sent     = 0;
    int unsigned       frames_sent    = 0;
    int unsigned       table_writes   = 0;
    int unsigned       redirects_seen = 0;
    int unsigned       passes_seen    = 0;
    int unsigned       stall_cycles   = 0;

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    l4_dst_port_frame_steering u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    task automatic report_mismatch(input string what, input int got, input int exp_v);
        err_count++;
        if (err_count <= MAX_PRINTED)
            $display("MISMATCH @%0t: %s got %0d, expected %0d", $time, what, got, exp_v);
    endtask

    // Verdict predictor: applies one accepted word to the shadow state
    function automatic void predict_word(input logic [OP_W-1:0] op, input logic [7:0] b,
                                         input logic last, input logic [QIDX_W-1:0] q,
                                         input logic [15:0] port, input logic flag);
        logic [15:0] etype;
        logic        redirect;
        result_t     r;
        case (op)
            OP_PORT_WR: port_flags[port] = flag;
            OP_SOCK_WR: if (q < SLOTS) sock_flags[q] = flag;
            OP_FRAME: begin
                if (pos_cnt == POS_ETYPE_HI) begin
                    hi_byte = b;
                end else if (pos_cnt == POS_ETYPE_LO) begin
                    etype = {hi_byte, b};
                    kind  = (etype == TYPE_V4) ? KIND_V4 :
                            (etype == TYPE_V6) ? KIND_V6 : KIND_OTHER;
                    hi_byte = '0;
                end else if (kind == KIND_V4) begin
                    if (pos_cnt == V4_HDR_POS && b[3:0] != IHL_PLAIN) hdr_good = 1'b0;
                    if (pos_cnt == V4_PROTO_POS && b != PROTO_TCP && b != PROTO_UDP)
                        hdr_good = 1'b0;
                    if (pos_cnt == V4_PORT_HI) hi_byte = b;
                    if (pos_cnt == V4_PORT_LO) port_hit = port_flags[{hi_byte, b}];
                end else if (kind == KIND_V6) begin
                    if (pos_cnt == V6_PROTO_POS && b != PROTO_TCP && b != PROTO_UDP)
                        hdr_good = 1'b0;
                    if (pos_cnt == V6_PORT_HI) hi_byte = b;
                    if (pos_cnt == V6_PORT_LO) port_hit = port_flags[{hi_byte, b}];
                end
                if (pos_cnt < POS_MAX) pos_cnt = pos_cnt + 1'b1;

                // last byte: one verdict, then per-frame state back to reset
                if (last) begin
                    redirect = (kind == KIND_V4 || kind == KIND_V6) && hdr_good &&
                               port_hit && q < SLOTS && sock_flags[q];
                    r.verdict      = redirect;
                    r.target_queue = redirect ? q : '0;
                    expected_verdicts.push_back(r);
                    pos_cnt  = '0;
                    kind     = KIND_NONE;
                    hdr_good = 1'b1;
                    hi_byte  = '0;
                    port_hit = 1'b0;
                end
            end
            default: ;
        endcase
    endfunction

    // Send one word: optional random gap, then hold until accepted
    task automatic send_word(input logic [OP_W-1:0] op, input logic [7:0] b, input logic last,
                             input logic [QIDX_W-1:0] q, input logic [15:0] port,
                             input logic flag);
        bit rdy;
        if (!no_idle && $urandom_range(0, 99) < 20) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tlast  <= last;
        s_tdata  <= {flag, port, q, b};
        do begin
            @(negedge aclk);
            rdy = s_tready;
            @(posedge aclk);
        end while (!rdy);
        predict_word(op, b, last, q, port, flag);
        if (op != OP_RSVD) words_sent++;
        if (op == OP_PORT_WR || op == OP_SOCK_WR) table_writes++;
    endtask

    // Sender pauses until every predicted verdict has come back
    task automatic wait_verdicts_drained;
        s_tvalid <= 1'b0;
        do @(posedge aclk);
        while (expected_verdicts.size() != 0);
    endtask

    function automatic void put_byte(input int idx, input logic [7:0] v);
        if (idx < frame_buf.size()) frame_buf[idx] = v;
    endfunction

    // Frame image: random bytes with the header fields of the chosen kind;
    // KIND_NONE leaves the bytes fully random. Fields past len are dropped.
    task automatic build_frame(input kind_t k, input int len, input logic [15:0] dport,
                               input logic [7:0] proto, input logic [3:0] ihl);
        logic [15:0] etype;
        frame_buf.delete();
        for (int i = 0; i < len; i++) frame_buf.push_back(8'($urandom_range(0, 255)));
        if (k == KIND_NONE) return;
        if (k == KIND_V4) begin
            etype = TYPE_V4;
        end else if (k == KIND_V6) begin
            etype = TYPE_V6;
        end else begin
            do etype = 16'($urandom_range(0, 65535));
            while (etype == TYPE_V4 || etype == TYPE_V6);
        end
        put_byte(POS_ETYPE_HI, etype[15:8]);
        put_byte(POS_ETYPE_LO, etype[7:0]);
        if (k == KIND_V4) begin
            put_byte(V4_HDR_POS, {4'($urandom_range(0, 15)), ihl});
            put_byte(V4_PROTO_POS, proto);
            put_byte(V4_PORT_HI, dport[15:8]);
            put_byte(V4_PORT_LO, dport[7:0]);
        end else if (k == KIND_V6) begin
            put_byte(V6_PROTO_POS, proto);
            put_byte(V6_PORT_HI, dport[15:8]);
            put_byte(V6_PORT_LO, dport[7:0]);
        end
    endtask

    // Stream frame_buf; one extra word may be slipped in before byte ins_at
    task automatic send_frame(input logic [QIDX_W-1:0] q, input int ins_at,
                              input logic [OP_W-1:0] ins_op, input logic [15:0] ins_port,
                              input logic ins_flag);
        int n;
        n = frame_buf.size();
        for (int i = 0; i < n; i++) begin
            if (i == ins_at)
                send_word(ins_op, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                          ins_port[QIDX_W-1:0], ins_port, ins_flag);
            send_word(OP_FRAME, frame_buf[i], i == n - 1,
                      (i == n - 1) ? q : 7'($urandom_range(0, 127)),
                      16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)));
        end
        frames_sent++;
    endtask

    task automatic send_plain(input kind_t k, input int len, input logic [15:0] dport,
                              input logic [7:0] proto, input logic [3:0] ihl,
                              input logic [QIDX_W-1:0] q);
        build_frame(k, len, dport, proto, ihl);
        send_frame(q, -1, OP_RSVD, '0, 1'b0);
    endtask

    // Table writes at the field extremes, plus an op 3 word with every bit high
    task automatic test_table_writes;
        send_word(OP_PORT_WR, 8'h00, 1'b0, 7'h00, 16'h0000, 1'b1);
        send_word(OP_PORT_WR, 8'hff, 1'b1, 7'h7f, 16'hffff, 1'b1);
        send_word(OP_PORT_WR, 8'h00, 1'b0, 7'h00, 16'd80, 1'b1);
        send_word(OP_SOCK_WR, 8'h00, 1'b0, 7'd0, 16'h0000, 1'b1);
        send_word(OP_SOCK_WR, 8'hff, 1'b1, 7'd127, 16'hffff, 1'b1);
        send_word(OP_SOCK_WR, 8'h00, 1'b0, 7'd5, 16'h0000, 1'b1);
        send_word(OP_RSVD, 8'hff, 1'b1, 7'h7f, 16'hffff, 1'b1);
    endtask

    task automatic test_ipv4_frames;
        send_plain(KIND_V4, 38, 16'hffff, PROTO_TCP, IHL_PLAIN, 7'd127);
        send_plain(KIND_V4, 60, 16'h0000, PROTO_UDP, IHL_PLAIN, 7'd0);
        send_plain(KIND_V4, 40, 16'd80, PROTO_TCP, 4'd6, 7'd5);       // options present
        send_plain(KIND_V4, 40, 16'd80, 8'd1, IHL_PLAIN, 7'd5);         // ICMP
        send_plain(KIND_V4, 90, 16'd80, PROTO_UDP, IHL_PLAIN, 7'd5);    // past position 63
    endtask

    task automatic test_ipv6_frames;
        send_plain(KIND_V6, 58, 16'd80, PROTO_UDP, IHL_PLAIN, 7'd5);
        send_plain(KIND_V6, 64, 16'd80, 8'd58, IHL_PLAIN, 7'd5);        // ICMPv6
        send_plain(KIND_OTHER, 60, 16'd80, PROTO_TCP, IHL_PLAIN, 7'd5);
    endtask

    // Frames that end before the port is complete must pass
    task automatic test_short_frames;
        send_plain(KIND_V4, 37, 16'd80, PROTO_TCP, IHL_PLAIN, 7'd5);
        send_plain(KIND_V6, 57, 16'd80, PROTO_TCP, IHL_PLAIN, 7'd5);
        send_plain(KIND_NONE, 1, 16'd80, PROTO_TCP, IHL_PLAIN, 7'd5);
        send_plain(KIND_NONE, 13, 16'd80, PROTO_TCP, IHL_PLAIN, 7'd5);
    endtask

    task automatic test_socket_absent;
        send_plain(KIND_V4, 40, 16'd80, PROTO_TCP, IHL_PLAIN, 7'd6);
        send_word(OP_SOCK_WR, 8'h00, 1'b0, 7'd5, 16'h0000, 1'b0);
        send_plain(KIND_V6, 60, 16'd80, PROTO_TCP, IHL_PLAIN, 7'd5);
        send_word(OP_SOCK_WR, 8'h00, 1'b0, 7'd5, 16'h0000, 1'b1);
    endtask

    // Port flag written after the port was latched must not count; before, it must
    task automatic test_port_write_timing;
        build_frame(KIND_V4, 40, 16'd1234, PROTO_TCP, IHL_PLAIN);
        send_frame(7'd5, int'(V4_PORT_LO) + 1, OP_PORT_WR, 16'd1234, 1'b1);
        build_frame(KIND_V4, 40, 16'd4321, PROTO_UDP, IHL_PLAIN);
        send_frame(7'd5, 20, OP_PORT_WR, 16'd4321, 1'b1);
        send_word(OP_PORT_WR, 8'h00, 1'b0, 7'd0, 16'h0000, 1'b0);
        send_plain(KIND_V4, 38, 16'h0000, PROTO_TCP, IHL_PLAIN, 7'd0);
    endtask

    task automatic test_random_traffic;
        kind_t           k;
        int              len, need, ins_at, pick, quiet_end;
        logic [15:0]     dport, ins_port;
        logic [OP_W-1:0] ins_op;
        logic [7:0]      proto;
        logic [3:0]      ihl;
        logic [QIDX_W-1:0] q;

        // hot ports keep redirects frequent; most sockets present
        for (int h = 0; h < HOT_PORTS; h++) begin
            hot_ports[h] = 16'($urandom_range(0, 65535));
            send_word(OP_PORT_WR, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                      7'($urandom_range(0, 127)), hot_ports[h], 1'b1);
        end
        for (int s = 0; s < SLOTS; s++)
            send_word(OP_SOCK_WR, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                      7'(s), 16'($urandom_range(0, 65535)), $urandom_range(0, 3) != 0);

        no_idle   = 1'b1;
        quiet_end = words_sent + QUIET_WORDS;
        while (words_sent < ITEM_TARGET) begin
            if (words_sent >= quiet_end) no_idle = 1'b0;
            pick  = $urandom_range(0, 99);
            q     = 7'($urandom_range(0, 127));
            k     = $urandom_range(0, 1) ? KIND_V4 : KIND_V6;
            need  = (k == KIND_V4) ? int'(V4_PORT_LO) + 1 : int'(V6_PORT_LO) + 1;
            len   = ($urandom_range(0, 99) < 80) ? need + $urandom_range(0, 8)
                                                 : $urandom_range(need, 100);
            dport = ($urandom_range(0, 99) < 85) ? hot_ports[$urandom_range(0, HOT_PORTS - 1)]
                                                 : 16'($urandom_range(0, 65535));
            proto = $urandom_range(0, 1) ? PROTO_TCP : PROTO_UDP;
            ihl   = IHL_PLAIN;
            case ($urandom_range(0, 2))
                0:       ins_op = OP_PORT_WR;
                1:       ins_op = OP_SOCK_WR;
                default: ins_op = OP_RSVD;
            endcase
            ins_port = $urandom_range(0, 1) ? hot_ports[$urandom_range(0, HOT_PORTS - 1)]
                                            : 16'($urandom_range(0, 65535));
            ins_at = ($urandom_range(0, 99) < 20) ? $urandom_range(0, 60) : -1;

            if (pick < 60) begin
                // well-formed TCP/UDP frame
                build_frame(k, len, dport, proto, ihl);
                send_frame(q, ins_at, ins_op, ins_port, $urandom_range(0, 3) != 0);
            end else if (pick < 75) begin
                // one header check broken
                case ($urandom_range(0, 3))
                    0: begin
                        k = KIND_V4;
                        do ihl = 4'($urandom_range(0, 15)); while (ihl == IHL_PLAIN);
                    end
                    1: begin
                        do proto = 8'($urandom_range(0, 255));
                        while (proto == PROTO_TCP || proto == PROTO_UDP);
                    end
                    2: k = KIND_OTHER;
                    default: len = $urandom_range(1, need - 1);
                endcase
                build_frame(k, len, dport, proto, ihl);
                send_frame(q, ins_at, ins_op, ins_port, 1'($urandom_range(0, 1)));
            end else if (pick < 85) begin
                // runt of random bytes
                build_frame(KIND_NONE, $urandom_range(1, 20), dport, proto, ihl);
                send_frame(q, -1, OP_RSVD, '0, 1'b0);
            end else begin
                // burst of table writes and op 3 noise
                repeat ($urandom_range(1, 4)) begin
                    case ($urandom_range(0, 2))
                        0:       ins_op = OP_PORT_WR;
                        1:       ins_op = OP_SOCK_WR;
                        default: ins_op = OP_RSVD;
                    endcase
                    send_word(ins_op, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                              7'($urandom_range(0, 127)),
                              $urandom_range(0, 1) ? hot_ports[$urandom_range(0, HOT_PORTS - 1)]
                                                   : 16'($urandom_range(0, 65535)),
                              $urandom_range(0, 3) != 0);
                end
            end
        end
        no_idle = 1'b0;
    endtask

    // Receiver back-pressure
    always @(posedge aclk) begin
        m_tready <= no_idle || ($urandom_range(0, 99) >= 30);
    end

    // Result check: a word moves at the coming edge when both are high now
    always @(negedge aclk) begin
        if (m_tvalid && m_tready) begin
            if (expected_verdicts.size() == 0) begin
                report_mismatch("verdict word with none expected, verdict", m_tuser, 0);
            end else begin
                want = expected_verdicts.pop_front();
                if (m_tuser !== want.verdict)
                    report_mismatch("verdict", m_tuser, want.verdict);
                if (m_tdata[QIDX_W-1:0] !== want.target_queue)
                    report_mismatch("target_queue", m_tdata[QIDX_W-1:0], want.target_queue);
                if (want.verdict) redirects_seen++;
                else passes_seen++;
            end
        end
    end

    // Watchdog on cycles where neither channel moves a word
    always @(negedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no word moved for %0d cycles", stall_cycles);
                $display("l4_dst_port_frame_steering regression: fail");
                $finish;
            end
        end
    end

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        test_table_writes();
        test_ipv4_frames();
        test_ipv6_frames();
        test_short_frames();
        test_socket_absent();
        test_port_write_timing();
        wait_verdicts_drained();
        test_random_traffic();
        wait_verdicts_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("covered %0d words: %0d frames (IPv4, IPv6, other, runts, long)",
                 words_sent, frames_sent);
        $display("  and %0d table writes; checked %0d verdicts: %0d redirected, %0d passed",
                 table_writes, redirects_seen + passes_seen, redirects_seen, passes_seen);
        if (err_count == 0 && expected_verdicts.size() == 0) begin
            $display("l4_dst_port_frame_steering regression: pass");
        end else begin
            $display("l4_dst_port_frame_steering regression: fail");
        end
        $finish;
    end

endmodule
